/* rtl/core/http_request_stream_tokenizer_unit_assert.svh */
// Assertion helpers shared by the tokenizer RTL.
// Each macro expects i_clk and i_rst_n to be visible in the enclosing module.
`ifndef HTTP_REQUEST_STREAM_TOKENIZER_UNIT_ASSERT_SVH
`define HTTP_REQUEST_STREAM_TOKENIZER_UNIT_ASSERT_SVH

`ifndef SYNTH
// Checked only out of reset.
`define HRST_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);
// Checked at every edge, reset included.
`define HRST_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) (expr)) else $error(msg);
`else
`define HRST_ASSERT(lbl, expr, msg)
`define HRST_ASSERT_ALWAYS(lbl, expr, msg)
`endif

`endif

/* rtl/core/hrst_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package hrst_pkg;

    // Delimiters and hex letters
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;

    // Token kinds
    localparam logic [2:0] KIND_METHOD  = 3'd0;
    localparam logic [2:0] KIND_URI     = 3'd1;
    localparam logic [2:0] KIND_VERSION = 3'd2;
    localparam logic [2:0] KIND_NAME    = 3'd3;
    localparam logic [2:0] KIND_VALUE   = 3'd4;
    localparam logic [2:0] KIND_BODY    = 3'd5;

    // Most results one input byte can cause
    localparam int unsigned MAX_RES = 3;

    // Parser phase, one-hot
    typedef enum logic [9:0] {
        PH_METHOD     = 10'b00_0000_0001,
        PH_URI        = 10'b00_0000_0010,
        PH_VERSION    = 10'b00_0000_0100,
        PH_VER_LF     = 10'b00_0000_1000,
        PH_NAME       = 10'b00_0001_0000,
        PH_VALUE      = 10'b00_0010_0000,
        PH_VAL_LF     = 10'b00_0100_0000,
        PH_LINE_START = 10'b00_1000_0000,
        PH_LINE_CR    = 10'b01_0000_0000,
        PH_BODY       = 10'b10_0000_0000
    } t_phase;

    // One result beat, without the last-of-run flag
    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] kind;
        logic       byte_valid;
        logic       token_end;
        logic       parse_error;
        logic       request_done;
    } t_result;

    // All results of one input byte
    typedef struct packed {
        logic [1:0]                 count;
        t_result [MAX_RES-1:0]      res;
    } t_bundle;

    // Queue status seen by both ends
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Hex digit decode: {is_hex, value}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= CH_UPPER_A && c <= CH_UPPER_F) ||
                     (c >= CH_LOWER_A && c <= CH_LOWER_F)) begin
            r = {1'b1, 4'(c[3:0] + 4'd9)};
        end
        return r;
    endfunction

    // Build a normal (non-error) result
    function automatic t_result mk_res(input logic [7:0] b, input logic [2:0] kind,
                                       input logic valid, input logic tend,
                                       input logic done);
        t_result r;
        r.out_byte     = b;
        r.kind         = kind;
        r.byte_valid   = valid;
        r.token_end    = tend;
        r.parse_error  = 1'b0;
        r.request_done = done;
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/hrst_stream_if.sv */
`timescale 1ns / 1ps
`default_nettype none

// Raw request bytes
interface hrst_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_message;

    modport source (output valid, output in_byte, output end_of_message, input ready);
    modport sink   (input valid, input in_byte, input end_of_message, output ready);
endinterface

// Tagged token beats
interface hrst_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [2:0] kind;
    logic       byte_valid;
    logic       token_end;
    logic       parse_error;
    logic       request_done;
    logic       last_of_run;

    modport source (output valid, output out_byte, output kind, output byte_valid,
                    output token_end, output parse_error, output request_done,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input kind, input byte_valid,
                    input token_end, input parse_error, input request_done,
                    input last_of_run, output ready);
endinterface

`default_nettype wire

/* rtl/core/hrst_front.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "http_request_stream_tokenizer_unit_assert.svh"

// Front end: takes one byte per beat, runs the request parser and hands the
// byte's results to the queue as one bundle.
module hrst_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    hrst_in_if.sink              i_in,
    input  hrst_pkg::t_q_stat    i_stat,
    output logic                 o_push,
    output hrst_pkg::t_bundle    o_bundle
);

    hrst_pkg::t_phase r_phase, n_phase;
    logic             r_first, n_first;
    logic [1:0]       r_pcnt,  n_pcnt;
    logic [7:0]       r_phi,   n_phi;
    logic             r_failed, n_failed;

    logic                                 accept;
    logic                                 bad;
    logic [1:0]                           nn;
    hrst_pkg::t_result [hrst_pkg::MAX_RES-1:0] res;
    logic [7:0]                           b;
    logic                                 eom;
    logic [4:0]                           hx_b;
    logic [4:0]                           hx_hi;

    assign i_in.ready = !i_stat.full;
    assign accept     = i_in.valid && i_in.ready;
    assign b          = i_in.in_byte;
    assign eom        = i_in.end_of_message;
    assign hx_b       = hrst_pkg::hex_decode(b);
    assign hx_hi      = hrst_pkg::hex_decode(r_phi);

    // Parser next state and results for the byte on the input
    always_comb begin
        n_phase  = r_phase;
        n_first  = r_first;
        n_pcnt   = r_pcnt;
        n_phi    = r_phi;
        n_failed = r_failed;
        bad      = 1'b0;
        nn       = 2'd0;
        res      = '0;

        if (r_failed || (eom && r_phase != hrst_pkg::PH_BODY)) begin
            bad = 1'b1;
        end else begin
            case (r_phase)
                hrst_pkg::PH_METHOD: begin
                    if (!r_first && b == hrst_pkg::CH_SPACE) begin
                        res[nn] = hrst_pkg::mk_res(8'd0, hrst_pkg::KIND_METHOD, 1'b0, 1'b1, 1'b0);
                        nn      = nn + 2'd1;
                        n_phase = hrst_pkg::PH_URI;
                        n_first = 1'b1;
                    end else begin
                        res[nn] = hrst_pkg::mk_res(b, hrst_pkg::KIND_METHOD, 1'b1, 1'b0, 1'b0);
                        nn      = nn + 2'd1;
                        n_first = 1'b0;
                    end
                end
                hrst_pkg::PH_URI: begin
                    if (!r_first && b == hrst_pkg::CH_SPACE) begin
                        // flush a dangling escape raw, then close the URI
                        if (r_pcnt != 2'd0) begin
                            res[nn] = hrst_pkg::mk_res(hrst_pkg::CH_PERCENT,
                                                       hrst_pkg::KIND_URI, 1'b1, 1'b0, 1'b0);
                            nn      = nn + 2'd1;
                        end
                        if (r_pcnt == 2'd2) begin
                            res[nn] = hrst_pkg::mk_res(r_phi, hrst_pkg::KIND_URI,
                                                       1'b1, 1'b0, 1'b0);
                            nn      = nn + 2'd1;
                        end
                        res[nn] = hrst_pkg::mk_res(8'd0, hrst_pkg::KIND_URI, 1'b0, 1'b1, 1'b0);
                        nn      = nn + 2'd1;
                        n_pcnt  = 2'd0;
                        n_phi   = 8'd0;
                        n_phase = hrst_pkg::PH_VERSION;
                        n_first = 1'b1;
                    end else begin
                        n_first = 1'b0;
                        if (r_pcnt == 2'd1 && hx_b[4]) begin
                            // first hex digit of an escape
                            n_pcnt = 2'd2;
                            n_phi  = b;
                        end else if (r_pcnt == 2'd2 && hx_b[4]) begin
                            // escape complete
                            res[nn] = hrst_pkg::mk_res({hx_hi[3:0], hx_b[3:0]},
                                                       hrst_pkg::KIND_URI, 1'b1, 1'b0, 1'b0);
                            nn      = nn + 2'd1;
                            n_pcnt  = 2'd0;
                            n_phi   = 8'd0;
                        end else begin
                            // broken escape goes out raw
                            if (r_pcnt != 2'd0) begin
                                res[nn] = hrst_pkg::mk_res(hrst_pkg::CH_PERCENT,
                                                           hrst_pkg::KIND_URI, 1'b1, 1'b0, 1'b0);
                                nn      = nn + 2'd1;
                            end
                            if (r_pcnt == 2'd2) begin
                                res[nn] = hrst_pkg::mk_res(r_phi, hrst_pkg::KIND_URI,
                                                           1'b1, 1'b0, 1'b0);
                                nn      = nn + 2'd1;
                            end
                            n_phi = 8'd0;
                            if (b == hrst_pkg::CH_PERCENT) begin
                                n_pcnt = 2'd1;
                            end else begin
                                n_pcnt  = 2'd0;
                                res[nn] = hrst_pkg::mk_res(b, hrst_pkg::KIND_URI,
                                                           1'b1, 1'b0, 1'b0);
                                nn      = nn + 2'd1;
                            end
                        end
                    end
                end
                hrst_pkg::PH_VERSION: begin
                    if (!r_first && b == hrst_pkg::CH_CR) begin
                        n_phase = hrst_pkg::PH_VER_LF;
                    end else begin
                        res[nn] = hrst_pkg::mk_res(b, hrst_pkg::KIND_VERSION, 1'b1, 1'b0, 1'b0);
                        nn      = nn + 2'd1;
                        n_first = 1'b0;
                    end
                end
                hrst_pkg::PH_VER_LF: begin
                    if (b != hrst_pkg::CH_LF) begin
                        bad = 1'b1;
                    end else begin
                        res[nn] = hrst_pkg::mk_res(8'd0, hrst_pkg::KIND_VERSION, 1'b0, 1'b1, 1'b0);
                        nn      = nn + 2'd1;
                        n_phase = hrst_pkg::PH_NAME;
                        n_first = 1'b1;
                    end
                end
                hrst_pkg::PH_NAME: begin
                    if (!r_first && b == hrst_pkg::CH_COLON) begin
                        res[nn] = hrst_pkg::mk_res(8'd0, hrst_pkg::KIND_NAME, 1'b0, 1'b1, 1'b0);
                        nn      = nn + 2'd1;
                        n_phase = hrst_pkg::PH_VALUE;
                        n_first = 1'b1;
                    end else begin
                        res[nn] = hrst_pkg::mk_res(b, hrst_pkg::KIND_NAME, 1'b1, 1'b0, 1'b0);
                        nn      = nn + 2'd1;
                        n_first = 1'b0;
                    end
                end
                hrst_pkg::PH_VALUE: begin
                    if (!r_first && b == hrst_pkg::CH_CR) begin
                        n_phase = hrst_pkg::PH_VAL_LF;
                    end else begin
                        res[nn] = hrst_pkg::mk_res(b, hrst_pkg::KIND_VALUE, 1'b1, 1'b0, 1'b0);
                        nn      = nn + 2'd1;
                        n_first = 1'b0;
                    end
                end
                hrst_pkg::PH_VAL_LF: begin
                    if (b != hrst_pkg::CH_LF) begin
                        bad = 1'b1;
                    end else begin
                        res[nn] = hrst_pkg::mk_res(8'd0, hrst_pkg::KIND_VALUE, 1'b0, 1'b1, 1'b0);
                        nn      = nn + 2'd1;
                        n_phase = hrst_pkg::PH_LINE_START;
                        n_first = 1'b1;
                    end
                end
                hrst_pkg::PH_LINE_START: begin
                    if (b == hrst_pkg::CH_CR) begin
                        n_phase = hrst_pkg::PH_LINE_CR;
                    end else begin
                        res[nn] = hrst_pkg::mk_res(b, hrst_pkg::KIND_NAME, 1'b1, 1'b0, 1'b0);
                        nn      = nn + 2'd1;
                        n_phase = hrst_pkg::PH_NAME;
                        n_first = 1'b0;
                    end
                end
                hrst_pkg::PH_LINE_CR: begin
                    if (b == hrst_pkg::CH_LF) begin
                        // blank line: headers done
                        n_phase = hrst_pkg::PH_BODY;
                        n_first = 1'b1;
                    end else begin
                        // lone CR opens the next header name
                        res[nn] = hrst_pkg::mk_res(hrst_pkg::CH_CR, hrst_pkg::KIND_NAME,
                                                   1'b1, 1'b0, 1'b0);
                        nn      = nn + 2'd1;
                        if (b == hrst_pkg::CH_COLON) begin
                            res[nn] = hrst_pkg::mk_res(8'd0, hrst_pkg::KIND_NAME,
                                                       1'b0, 1'b1, 1'b0);
                            nn      = nn + 2'd1;
                            n_phase = hrst_pkg::PH_VALUE;
                            n_first = 1'b1;
                        end else begin
                            res[nn] = hrst_pkg::mk_res(b, hrst_pkg::KIND_NAME,
                                                       1'b1, 1'b0, 1'b0);
                            nn      = nn + 2'd1;
                            n_phase = hrst_pkg::PH_NAME;
                            n_first = 1'b0;
                        end
                    end
                end
                hrst_pkg::PH_BODY: begin
                    res[nn] = hrst_pkg::mk_res(b, hrst_pkg::KIND_BODY, 1'b1, eom, eom);
                    nn      = nn + 2'd1;
                    n_first = 1'b0;
                end
                default: begin
                    bad = 1'b1;
                end
            endcase
        end

        // error replaces whatever the byte would have given
        if (bad) begin
            res                = '0;
            res[0].parse_error = 1'b1;
            nn                 = 2'd1;
            n_failed           = 1'b1;
            n_pcnt             = 2'd0;
            n_phi              = 8'd0;
        end

        // end of message always leaves the parser ready for the next one
        if (eom) begin
            n_phase  = hrst_pkg::PH_METHOD;
            n_first  = 1'b1;
            n_pcnt   = 2'd0;
            n_phi    = 8'd0;
            n_failed = 1'b0;
        end
    end

    assign o_push         = accept && (nn != 2'd0);
    assign o_bundle.count = nn;
    assign o_bundle.res   = res;

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= hrst_pkg::PH_METHOD;
            r_first  <= 1'b1;
            r_pcnt   <= 2'd0;
            r_phi    <= 8'd0;
            r_failed <= 1'b0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_first  <= n_first;
            r_pcnt   <= n_pcnt;
            r_phi    <= n_phi;
            r_failed <= n_failed;
        end
    end

    `HRST_ASSERT(a_pend_only_in_uri, (r_pcnt != 2'd0) |-> (r_phase == hrst_pkg::PH_URI), "escape pending outside URI")
    `HRST_ASSERT(a_pend_cnt_range, r_pcnt != 2'd3, "escape count out of range")
    `HRST_ASSERT(a_no_push_when_full, !(o_push && i_stat.full), "push into full queue")

endmodule

`default_nettype wire

/* rtl/core/hrst_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "http_request_stream_tokenizer_unit_assert.svh"

// Bundle queue between the parser and the beat serializer.
module hrst_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  hrst_pkg::t_bundle    i_push_data,
    input  wire                  i_pop,
    output hrst_pkg::t_bundle    o_head,
    output hrst_pkg::t_q_stat    o_stat
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    hrst_pkg::t_bundle r_mem [DEPTH];
    logic [PW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]     r_count,  n_count;
    logic              do_push;
    logic              do_pop;

    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd_ptr];

    // Pointer wrap and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : PW'(r_wr_ptr + 1'b1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : PW'(r_rd_ptr + 1'b1);
        end
        if (do_push && !do_pop) begin
            n_count = CW'(r_count + 1'b1);
        end else if (do_pop && !do_push) begin
            n_count = CW'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage, no reset
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    `HRST_ASSERT(a_count_bound, r_count <= CW'(DEPTH), "queue count above depth")
    `HRST_ASSERT(a_no_empty_bundle, o_stat.empty || (o_head.count != 2'd0), "empty bundle queued")
    `HRST_ASSERT(a_full_not_empty, !(o_stat.full && o_stat.empty), "queue both full and empty")

endmodule

`default_nettype wire

/* rtl/core/hrst_back.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "http_request_stream_tokenizer_unit_assert.svh"

// Back end: head bundle to output register, one result per cycle unless stalled.
module hrst_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  hrst_pkg::t_bundle    i_head,
    input  hrst_pkg::t_q_stat    i_stat,
    output logic                 o_pop,
    hrst_out_if.source           o_out
);

    logic              r_valid;
    hrst_pkg::t_result r_res;
    logic              r_last;
    logic [1:0]        r_idx, n_idx;
    logic              load;
    logic              take;
    logic              is_last;

    // Output register frees when empty or being taken
    assign load    = !r_valid || o_out.ready;
    assign take    = load && !i_stat.empty;
    assign is_last = (r_idx == 2'(i_head.count - 2'd1));
    assign o_pop   = take && is_last;

    always_comb begin
        n_idx = r_idx;
        if (take) begin
            n_idx = is_last ? 2'd0 : 2'(r_idx + 2'd1);
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= !i_stat.empty;
            end
            r_idx <= n_idx;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res  <= i_head.res[r_idx];
            r_last <= is_last;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.out_byte     = r_res.out_byte;
    assign o_out.kind         = r_res.kind;
    assign o_out.byte_valid   = r_res.byte_valid;
    assign o_out.token_end    = r_res.token_end;
    assign o_out.parse_error  = r_res.parse_error;
    assign o_out.request_done = r_res.request_done;
    assign o_out.last_of_run  = r_last;

    `HRST_ASSERT(a_idx_range, r_idx != 2'd3, "result index out of range")
    `HRST_ASSERT(a_idx_idle, i_stat.empty |-> (r_idx == 2'd0), "index left mid-bundle with queue empty")
    `HRST_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !r_valid, "output valid right after reset")

endmodule

`default_nettype wire

/* rtl/core/http_request_stream_tokenizer_unit.sv */
// HTTP request stream tokenizer.
// Input channel i_in: one raw request byte per beat (in_byte), with
// end_of_message high on the last byte of a message. Output channel o_out:
// tagged beats carrying out_byte, kind, byte_valid, token_end, parse_error,
// request_done and last_of_run (high on the final beat caused by one byte).
// Each input byte gives zero to three output beats.
// A byte's bundle is written into the queue when the byte is accepted; its
// first beat then goes from the queue head into the output register.
// Throughput: one input byte per cycle while the queue is not full, and one
// output beat per cycle while o_out.ready is high. The output beat rate is the
// limit, so bytes that give two or three beats (broken escapes, URI close with
// a pending escape, lone CR in headers) hold the output side for each beat.
// A queue of QUEUE_DEPTH bundles sits between the parser and the output
// register; i_in.ready drops only when it is full, so the input keeps flowing
// while a finished beat waits on a stalled receiver.
// Reset (synchronous, active low) empties the queue and output register and
// puts the parser at the start of a method. After an end_of_message byte the
// parser is back in that state for the next message.
`timescale 1ns / 1ps
`default_nettype none

module http_request_stream_tokenizer_unit #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    hrst_in_if.sink      i_in,
    hrst_out_if.source   o_out
);

    hrst_pkg::t_q_stat stat;
    hrst_pkg::t_bundle push_data;
    hrst_pkg::t_bundle head;
    logic              push;
    logic              pop;

    hrst_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_stat   (stat),
        .o_push   (push),
        .o_bundle (push_data)
    );

    hrst_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head      (head),
        .o_stat      (stat)
    );

    hrst_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_stat  (stat),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

/* bench/token_beat_checker.sv */
`timescale 1ns / 1ps

// Watches both tokenizer channels. Each accepted request byte is run through a
// local copy of the parser; the beats it must produce are queued and every
// beat on the output is compared, field by field, with the oldest one queued.
module token_beat_checker (
    input  wire  i_clk,
    input  wire  i_rst_n,
    hrst_in_if   in_ch,
    hrst_out_if  out_ch,
    output int   o_mismatches,
    output int   o_pending,
    output int   o_beats,
    output int   o_requests,
    output int   o_error_beats
);
    import hrst_pkg::*;

    localparam int HEX_RADIX  = 16;
    localparam int HEX_LETTER = 10;
    localparam int MAX_SHOWN  = 10;

    typedef struct packed {
        t_result res;
        logic    last;
    } t_token_beat;

    // parser copy
    t_phase     parse_phase;
    logic       at_token_start;
    logic [1:0] esc_count;
    logic [7:0] esc_hi;
    logic       in_error;

    // beats caused by the current byte
    t_result    run_buf [MAX_RES];
    int         run_len;

    t_token_beat beats_due [$];

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
        if (c >= CH_UPPER_A && c <= CH_UPPER_F) return int'(c - CH_UPPER_A) + HEX_LETTER;
        if (c >= CH_LOWER_A && c <= CH_LOWER_F) return int'(c - CH_LOWER_A) + HEX_LETTER;
        return -1;
    endfunction

    function automatic void restart();
        parse_phase    = PH_METHOD;
        at_token_start = 1'b1;
        esc_count      = 2'd0;
        esc_hi         = 8'h00;
        in_error       = 1'b0;
    endfunction

    function automatic void emit(input logic [7:0] b, input logic [2:0] k, input logic v,
                                 input logic te, input logic err, input logic dn);
        if (run_len < MAX_RES) begin
            run_buf[run_len].out_byte     = b;
            run_buf[run_len].kind         = k;
            run_buf[run_len].byte_valid   = v;
            run_buf[run_len].token_end    = te;
            run_buf[run_len].parse_error  = err;
            run_buf[run_len].request_done = dn;
            run_len = run_len + 1;
        end
    endfunction

    // URI content byte through the percent decoder
    function automatic void uri_char(input logic [7:0] b);
        if (esc_count == 2'd1) begin
            if (hex_digit(b) >= 0) begin
                esc_count = 2'd2;
                esc_hi    = b;
                return;
            end
            emit(CH_PERCENT, KIND_URI, 1'b1, 1'b0, 1'b0, 1'b0);
        end else if (esc_count == 2'd2) begin
            if (hex_digit(b) >= 0) begin
                emit(8'(hex_digit(esc_hi) * HEX_RADIX + hex_digit(b)), KIND_URI,
                     1'b1, 1'b0, 1'b0, 1'b0);
                esc_count = 2'd0;
                esc_hi    = 8'h00;
                return;
            end
            // broken escape: both held bytes go out raw
            emit(CH_PERCENT, KIND_URI, 1'b1, 1'b0, 1'b0, 1'b0);
            emit(esc_hi, KIND_URI, 1'b1, 1'b0, 1'b0, 1'b0);
        end
        esc_count = 2'd0;
        esc_hi    = 8'h00;
        if (b == CH_PERCENT) begin
            esc_count = 2'd1;
            return;
        end
        emit(b, KIND_URI, 1'b1, 1'b0, 1'b0, 1'b0);
    endfunction

    // Fills run_buf with the beats one request byte causes
    function automatic void tokenize(input logic [7:0] b, input logic eom);
        logic bad;
        bad     = 1'b0;
        run_len = 0;
        if (in_error || (eom && parse_phase != PH_BODY)) begin
            bad = 1'b1;
        end else begin
            case (parse_phase)
                PH_METHOD: begin
                    if (!at_token_start && b == CH_SPACE) begin
                        emit(8'h00, KIND_METHOD, 1'b0, 1'b1, 1'b0, 1'b0);
                        parse_phase    = PH_URI;
                        at_token_start = 1'b1;
                    end else begin
                        emit(b, KIND_METHOD, 1'b1, 1'b0, 1'b0, 1'b0);
                        at_token_start = 1'b0;
                    end
                end
                PH_URI: begin
                    if (!at_token_start && b == CH_SPACE) begin
                        // flush a dangling escape before closing
                        if (esc_count >= 2'd1)
                            emit(CH_PERCENT, KIND_URI, 1'b1, 1'b0, 1'b0, 1'b0);
                        if (esc_count >= 2'd2)
                            emit(esc_hi, KIND_URI, 1'b1, 1'b0, 1'b0, 1'b0);
                        emit(8'h00, KIND_URI, 1'b0, 1'b1, 1'b0, 1'b0);
                        esc_count      = 2'd0;
                        esc_hi         = 8'h00;
                        parse_phase    = PH_VERSION;
                        at_token_start = 1'b1;
                    end else begin
                        uri_char(b);
                        at_token_start = 1'b0;
                    end
                end
                PH_VERSION: begin
                    if (!at_token_start && b == CH_CR) begin
                        parse_phase = PH_VER_LF;
                    end else begin
                        emit(b, KIND_VERSION, 1'b1, 1'b0, 1'b0, 1'b0);
                        at_token_start = 1'b0;
                    end
                end
                PH_VER_LF: begin
                    if (b != CH_LF) begin
                        bad = 1'b1;
                    end else begin
                        emit(8'h00, KIND_VERSION, 1'b0, 1'b1, 1'b0, 1'b0);
                        parse_phase    = PH_NAME;
                        at_token_start = 1'b1;
                    end
                end
                PH_NAME: begin
                    if (!at_token_start && b == CH_COLON) begin
                        emit(8'h00, KIND_NAME, 1'b0, 1'b1, 1'b0, 1'b0);
                        parse_phase    = PH_VALUE;
                        at_token_start = 1'b1;
                    end else begin
                        emit(b, KIND_NAME, 1'b1, 1'b0, 1'b0, 1'b0);
                        at_token_start = 1'b0;
                    end
                end
                PH_VALUE: begin
                    if (!at_token_start && b == CH_CR) begin
                        parse_phase = PH_VAL_LF;
                    end else begin
                        emit(b, KIND_VALUE, 1'b1, 1'b0, 1'b0, 1'b0);
                        at_token_start = 1'b0;
                    end
                end
                PH_VAL_LF: begin
                    if (b != CH_LF) begin
                        bad = 1'b1;
                    end else begin
                        emit(8'h00, KIND_VALUE, 1'b0, 1'b1, 1'b0, 1'b0);
                        parse_phase    = PH_LINE_START;
                        at_token_start = 1'b1;
                    end
                end
                PH_LINE_START: begin
                    if (b == CH_CR) begin
                        parse_phase = PH_LINE_CR;
                    end else begin
                        emit(b, KIND_NAME, 1'b1, 1'b0, 1'b0, 1'b0);
                        parse_phase    = PH_NAME;
                        at_token_start = 1'b0;
                    end
                end
                PH_LINE_CR: begin
                    if (b == CH_LF) begin
                        parse_phase    = PH_BODY;
                        at_token_start = 1'b1;
                    end else begin
                        // lone CR: it opens the next header name
                        emit(CH_CR, KIND_NAME, 1'b1, 1'b0, 1'b0, 1'b0);
                        if (b == CH_COLON) begin
                            emit(8'h00, KIND_NAME, 1'b0, 1'b1, 1'b0, 1'b0);
                            parse_phase    = PH_VALUE;
                            at_token_start = 1'b1;
                        end else begin
                            emit(b, KIND_NAME, 1'b1, 1'b0, 1'b0, 1'b0);
                            parse_phase    = PH_NAME;
                            at_token_start = 1'b0;
                        end
                    end
                end
                PH_BODY: begin
                    emit(b, KIND_BODY, 1'b1, eom, 1'b0, eom);
                    at_token_start = 1'b0;
                    if (eom) restart();
                end
                default: bad = 1'b1;
            endcase
        end

        // error beat carries kind method and nothing else
        if (bad) begin
            run_len = 0;
            emit(8'h00, KIND_METHOD, 1'b0, 1'b0, 1'b1, 1'b0);
            in_error  = 1'b1;
            esc_count = 2'd0;
            esc_hi    = 8'h00;
            if (eom) restart();
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_token_beat due;
        logic        bad_beat;
        int          i;
        if (!i_rst_n) begin
            restart();
            beats_due.delete();
            o_mismatches  = 0;
            o_beats       = 0;
            o_requests    = 0;
            o_error_beats = 0;
        end else begin
            // output beat against the oldest prediction
            if (out_ch.valid && out_ch.ready) begin
                o_beats = o_beats + 1;
                if (out_ch.parse_error === 1'b1) o_error_beats = o_error_beats + 1;
                if (out_ch.request_done === 1'b1) o_requests = o_requests + 1;
                if (beats_due.size() == 0) begin
                    o_mismatches = o_mismatches + 1;
                    if (o_mismatches <= MAX_SHOWN)
                        $display("checker: unpredicted beat byte=%h kind=%0d err=%b at %0t",
                                 out_ch.out_byte, out_ch.kind, out_ch.parse_error, $realtime);
                end else begin
                    due = beats_due.pop_front();
                    bad_beat = (out_ch.out_byte     !== due.res.out_byte)
                            || (out_ch.kind         !== due.res.kind)
                            || (out_ch.byte_valid   !== due.res.byte_valid)
                            || (out_ch.token_end    !== due.res.token_end)
                            || (out_ch.parse_error  !== due.res.parse_error)
                            || (out_ch.request_done !== due.res.request_done)
                            || (out_ch.last_of_run  !== due.last);
                    if (bad_beat) begin
                        o_mismatches = o_mismatches + 1;
                        if (o_mismatches <= MAX_SHOWN) begin
                            $display("checker: beat %0d exp byte=%h kind=%0d bv=%b te=%b err=%b dn=%b last=%b",
                                     o_beats, due.res.out_byte, due.res.kind,
                                     due.res.byte_valid, due.res.token_end,
                                     due.res.parse_error, due.res.request_done, due.last);
                            $display("checker: beat %0d got byte=%h kind=%0d bv=%b te=%b err=%b dn=%b last=%b",
                                     o_beats, out_ch.out_byte, out_ch.kind,
                                     out_ch.byte_valid, out_ch.token_end,
                                     out_ch.parse_error, out_ch.request_done,
                                     out_ch.last_of_run);
                        end
                    end
                end
            end

            // accepted request byte: queue what it must produce
            if (in_ch.valid && in_ch.ready) begin
                tokenize(in_ch.in_byte, in_ch.end_of_message);
                for (i = 0; i < run_len; i++) begin
                    due.res  = run_buf[i];
                    due.last = (i == run_len - 1);
                    beats_due.push_back(due);
                end
            end
        end
        o_pending = beats_due.size();
    end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

// Feeds request messages into the tokenizer: a few hand-built ones that hit the
// corner cases, then random requests (mostly well formed, some cut short,
// missing an LF or plain noise). Both channels idle at random.
module tb_top;
    import hrst_pkg::*;

    localparam int RANDOM_BYTES = 320;
    localparam int DRAIN_CYCLES = 20;
    localparam int LONG_HOLD    = 120;

    logic clk;
    logic rst_n;

    hrst_in_if  in_ch ();
    hrst_out_if out_ch ();

    int mismatches;
    int pending;
    int beats_seen;
    int requests_done;
    int error_beats;

    int bytes_sent;
    int msgs_sent;
    int random_bytes;

    logic [7:0] msg_q [$];
    logic       tx_no_gaps;

    http_request_stream_tokenizer_unit u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    token_beat_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .o_mismatches  (mismatches),
        .o_pending     (pending),
        .o_beats       (beats_seen),
        .o_requests    (requests_done),
        .o_error_beats (error_beats)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    function automatic bit one_in(input int n);
        return $urandom_range(0, n - 1) == 0;
    endfunction

    function automatic logic [7:0] pick_letter();
        logic [7:0] base;
        base = $urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A;
        return base + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] pick_hex_char();
        int sel;
        sel = $urandom_range(0, 21);
        if (sel < 10) return CH_ZERO + 8'(sel);
        if (sel < 16) return CH_UPPER_A + 8'(sel - 10);
        return CH_LOWER_A + 8'(sel - 16);
    endfunction

    // URI bytes lean on '%' and hex digits so escapes form and break often
    function automatic logic [7:0] pick_uri_char();
        case ($urandom_range(0, 9))
            0, 1, 2: return CH_PERCENT;
            3, 4, 5: return pick_hex_char();
            6, 7:    return pick_letter();
            8:       return 8'h2F;
            default: return 8'($urandom_range(8'h21, 8'h7E));
        endcase
    endfunction

    // token text; values may also carry spaces and colons
    function automatic logic [7:0] pick_field_char(input bit in_value);
        if (in_value && one_in(4)) return one_in(2) ? CH_SPACE : CH_COLON;
        case ($urandom_range(0, 5))
            0:       return CH_ZERO + 8'($urandom_range(0, 9));
            1:       return 8'h2D;
            2:       return 8'h2E;
            default: return pick_letter();
        endcase
    endfunction

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) msg_q.push_back(s[i]);
    endtask

    // one request with random content, well formed unless it has no header line
    task automatic build_request();
        int n;
        int lines;
        // method
        msg_q.push_back(one_in(8) ? CH_SPACE : pick_letter());
        repeat ($urandom_range(0, 3)) msg_q.push_back(pick_letter());
        msg_q.push_back(CH_SPACE);
        // uri
        msg_q.push_back(one_in(8) ? CH_SPACE : pick_uri_char());
        repeat ($urandom_range(0, 6)) msg_q.push_back(pick_uri_char());
        msg_q.push_back(CH_SPACE);
        // version
        msg_q.push_back(one_in(8) ? CH_CR : pick_field_char(1'b0));
        repeat ($urandom_range(0, 4)) msg_q.push_back(pick_field_char(1'b0));
        msg_q.push_back(CH_CR);
        msg_q.push_back(CH_LF);
        // header lines; no line at all leaves the block stuck in a name
        lines = one_in(10) ? 0 : $urandom_range(1, 3);
        for (n = 0; n < lines; n++) begin
            if (n > 0 && one_in(4)) begin
                // lone CR at line start, possibly straight into the colon
                msg_q.push_back(CH_CR);
                repeat ($urandom_range(0, 2)) msg_q.push_back(pick_field_char(1'b0));
            end else begin
                msg_q.push_back(one_in(8) ? CH_COLON : pick_field_char(1'b0));
                repeat ($urandom_range(0, 3)) msg_q.push_back(pick_field_char(1'b0));
            end
            msg_q.push_back(CH_COLON);
            if (one_in(4))
                msg_q.push_back(CH_SPACE);
            else if (one_in(6))
                msg_q.push_back(CH_CR);
            else
                msg_q.push_back(pick_field_char(1'b1));
            repeat ($urandom_range(0, 4)) msg_q.push_back(pick_field_char(1'b1));
            msg_q.push_back(CH_CR);
            msg_q.push_back(CH_LF);
        end
        msg_q.push_back(CH_CR);
        msg_q.push_back(CH_LF);
        // body; left empty now and then
        if (!one_in(10))
            repeat ($urandom_range(1, 6)) msg_q.push_back(8'($urandom_range(0, 255)));
    endtask

    // one request byte; valid stays up when the next byte follows at once
    task automatic send_byte(input logic [7:0] b, input logic eom);
        int gap;
        gap = tx_no_gaps ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.in_byte        <= b;
        in_ch.end_of_message <= eom;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
    endtask

    task automatic send_message();
        int i;
        tx_no_gaps = one_in(4);
        for (i = 0; i < msg_q.size(); i++) send_byte(msg_q[i], i == msg_q.size() - 1);
        bytes_sent = bytes_sent + msg_q.size();
        msgs_sent  = msgs_sent + 1;
        msg_q.delete();
    endtask

    // receiver: random stalls, bursts with none, and two long hold-offs
    initial begin : receiver
        int   stall;
        int   taken;
        logic burst;
        out_ch.ready <= 1'b0;
        taken = 0;
        burst = 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            if (taken % 40 == 0) burst = one_in(3);
            if (taken == 100 || taken == 500)
                stall = LONG_HOLD;
            else
                stall = burst ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid) @(posedge clk);
            taken = taken + 1;
        end
    end

    initial begin : stimulus
        logic [7:0] junk;
        int         cut;
        int         n;
        int         idx;
        bytes_sent   = 0;
        msgs_sent    = 0;
        random_bytes = 0;
        tx_no_gaps   = 1'b0;
        rst_n                <= 1'b0;
        in_ch.valid          <= 1'b0;
        in_ch.in_byte        <= 8'h00;
        in_ch.end_of_message <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // leading delimiters as content, lowercase escape, escape cut by the
        // closing space, CR as first version and value byte, byte extremes in body
        push_text("  %4a%4 \r1\r\na:\r\r\n\r\n");
        msg_q.push_back(8'hFF);
        msg_q.push_back(8'h00);
        send_message();
        // missing LF after the version, error carried to the end byte
        push_text("A B C\rXY");
        send_message();
        // end of message on the very first byte
        push_text("G");
        send_message();

        // random requests: mostly well formed, some broken
        while (random_bytes < RANDOM_BYTES) begin
            case ($urandom_range(0, 9))
                7: begin
                    // cut short at a random byte
                    build_request();
                    cut = $urandom_range(1, msg_q.size());
                    while (msg_q.size() > cut) junk = msg_q.pop_back();
                end
                8: begin
                    // one LF replaced
                    build_request();
                    for (n = 0; n < 64; n++) begin
                        idx = $urandom_range(0, msg_q.size() - 1);
                        if (msg_q[idx] == CH_LF) begin
                            junk = 8'($urandom_range(0, 255));
                            msg_q[idx] = (junk == CH_LF) ? CH_SPACE : junk;
                            break;
                        end
                    end
                end
                9: begin
                    repeat ($urandom_range(1, 12)) msg_q.push_back(8'($urandom_range(0, 255)));
                end
                default: build_request();
            endcase
            random_bytes = random_bytes + msg_q.size();
            send_message();
        end
        in_ch.valid <= 1'b0;

        // wait out the remaining beats, then watch for strays
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb_top: %0d bytes in %0d messages, %0d beats checked", bytes_sent,
                 msgs_sent, beats_seen);
        $display("tb_top: %0d requests completed, %0d error beats, %0d mismatches",
                 requests_done, error_beats, mismatches);
        if (mismatches == 0 && pending == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

/* http_request_stream_tokenizer_unit.f */
+incdir+rtl/core
rtl/core/hrst_pkg.sv
rtl/core/hrst_stream_if.sv
rtl/core/hrst_front.sv
rtl/core/hrst_queue.sv
rtl/core/hrst_back.sv
rtl/core/http_request_stream_tokenizer_unit.sv
bench/token_beat_checker.sv
bench/tb_top.sv
